>>> design/adaptive_frequency_estimator_defines.svh
// assertion helpers for the estimator module
`ifndef ADAPTIVE_FREQUENCY_ESTIMATOR_DEFINES_SVH
`define ADAPTIVE_FREQUENCY_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define AFE_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("afe assertion failed");

// next-cycle implication
`define AFE_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("afe assertion failed");

`endif

>>> design/afe_pkg.sv
`default_nettype none
package afe_pkg;

  localparam int unsigned COS_TABLE_BITS_DEF = 10;
  localparam int unsigned CFG_DW = 24;
  localparam int unsigned TWO_PI_Q20 = 6588397;
  localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;
  localparam logic [23:0] STEP_SIZE_RESET = 24'd16777;
  localparam logic [23:0] INIT_ANGLE_RESET = 24'd0;
  localparam logic signed [26:0] ANGLE_MAX = 27'sd8388607;
  localparam logic signed [26:0] ANGLE_MIN = -27'sd8388608;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_STEP_SIZE  = 1'b0,
    CFG_INIT_ANGLE = 1'b1
  } cfg_idx_e;

  // quarter-wave cosine entry k in Q1.15, Taylor series in Q4.28
  function automatic logic [15:0] quarter_cos(int unsigned k, int unsigned bits);
    logic [63:0] nq;
    logic [63:0] x;
    logic [63:0] xx;
    logic [63:0] term;
    logic [63:0] r;
    logic signed [63:0] sum;
    nq = 64'd1 << bits;
    x = (64'(k) * HALF_PI_Q28 + (nq >> 1)) >> bits;
    xx = (x * x + (64'd1 << 27)) >> 28;
    term = 64'd1 << 28;
    sum = signed'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * xx) >> 28) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) + 64'd4096) >> 13;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

>>> design/afe_cos_rom.sv
`default_nettype none
module afe_cos_rom #(
  parameter int unsigned TABLE_BITS = afe_pkg::COS_TABLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic [TABLE_BITS:0]   addr_i,
  output logic      [14:0]           data_o
);
  import afe_pkg::*;

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  logic [14:0] rom [DEPTH];
  logic [14:0] data_q;

  // table entries worked out at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom[k] = 15'(quarter_cos(k, TABLE_BITS));
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

>>> design/afe_mul.sv
`default_nettype none
module afe_mul (
  input  wire logic               clk_i,
  input  wire logic signed [24:0] a_i,
  input  wire logic signed [19:0] b_i,
  output logic signed [44:0]      p_o
);
  import afe_pkg::*;

  logic signed [44:0] p_q;

  // shared signed multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q <= 45'(a_i) * 45'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> design/adaptive_frequency_estimator.sv
// Adaptive frequency estimator: tracks the angle per sample of a sinusoid.
// Input channel (in_valid_i / in_stall_o) carries mode_i and sample_i; a request
// is taken when valid is high and stall is low. mode_i = 1 restarts: history
// cleared and the angle set to the initial_angle register.
// Output channel (out_valid_o / out_stall_i) carries one angle_o per request.
// A sample runs through a small sequencer: angle wrap, a reciprocal multiply for
// the phase index with a compare and subtract fix-up, a cosine table read and
// seven passes through one shared 25x20 multiplier; a restart goes straight to
// the output step. in_stall_o is high while a request is at work; the next
// request is taken once the result sits in the output register.
// When the receiver stalls the result holds in that register; a later result
// waits in the last sequencer step until the register is free.
// Reset clears history, sets step_size and initial_angle to their defaults and
// the angle to the default initial angle; the block is ready right after reset.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered.
`default_nettype none
`include "adaptive_frequency_estimator_defines.svh"
module adaptive_frequency_estimator #(
  parameter int unsigned COS_TABLE_BITS = afe_pkg::COS_TABLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic signed [15:0]          sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [23:0]               angle_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_index_i,
  input  wire logic [afe_pkg::CFG_DW-1:0]  cfg_data_i
);
  import afe_pkg::*;

  localparam int unsigned B  = COS_TABLE_BITS;
  localparam int unsigned QW = B + 3;
  localparam int unsigned NW = 23 + QW + 1;
  localparam int unsigned RS = 42 - QW;
  localparam logic [24:0] TP  = 25'(TWO_PI_Q20);
  localparam logic [24:0] DEN = 25'(2 * TWO_PI_Q20);
  localparam logic [63:0] RECIP = (64'd1 << 42) / 64'(2 * TWO_PI_Q20);

  typedef enum logic [17:0] {
    ST_IDLE   = 18'b000000000000000001,
    ST_WRAP   = 18'b000000000000000010,
    ST_QEST   = 18'b000000000000000100,
    ST_QMUL   = 18'b000000000000001000,
    ST_QREM   = 18'b000000000000010000,
    ST_QFIX   = 18'b000000000000100000,
    ST_ADDR   = 18'b000000000001000000,
    ST_ROM    = 18'b000000000010000000,
    ST_COS    = 18'b000000000100000000,
    ST_MUL_S  = 18'b000000001000000000,
    ST_MUL_G  = 18'b000000010000000000,
    ST_G      = 18'b000000100000000000,
    ST_MUL_EG = 18'b000001000000000000,
    ST_EG     = 18'b000010000000000000,
    ST_MUL_HI = 18'b000100000000000000,
    ST_ACC    = 18'b001000000000000000,
    ST_RND    = 18'b010000000000000000,
    ST_OUT    = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [23:0]        mu_q;
  logic signed [23:0] init_q;
  logic signed [23:0] angle_q;
  logic signed [15:0] x_q, x1_q, x2_q;
  logic signed [24:0] a_q;
  logic [24:0]        rem_q;
  logic [QW-1:0]      p_q;
  logic [B:0]         addr_q;
  logic               neg_q;
  logic signed [16:0] c_q;
  logic signed [19:0] e_q, g_q;
  logic signed [35:0] eg_q;
  logic signed [59:0] acc_q;
  logic               out_valid_q;
  logic signed [23:0] out_angle_q;

  logic               in_acc;
  logic               out_free;
  logic [NW-1:0]      n_full;
  logic [QW-1:0]      pp;
  logic [B-1:0]       pr;
  logic [1:0]         pq;
  logic [14:0]        rom_data;
  logic signed [24:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [44:0] prod;
  logic signed [44:0] s_rnd, g_rnd;
  logic signed [59:0] d_rnd;
  logic signed [26:0] nw;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // wrapped angle scaled to the phase index numerator
  assign n_full = NW'({a_q[22:0], {QW{1'b0}}}) + NW'(TP);

  // phase index split into quadrant and offset
  assign pp = p_q[B+2] ? '0 : p_q;
  assign pq = pp[B+1:B];
  assign pr = pp[B-1:0];

  // rounding to nearest, ties away from zero
  assign s_rnd = (prod + 45'sd8192 - signed'(45'(prod[44]))) >>> 14;
  assign g_rnd = (prod + 45'sd16384 - signed'(45'(prod[44]))) >>> 15;
  assign d_rnd = (acc_q + (60'sd1 <<< 33) - signed'(60'(acc_q[59]))) >>> 34;
  assign nw    = 27'(angle_q) - 27'(d_rnd);

  afe_cos_rom #(
    .TABLE_BITS(B)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(addr_q),
    .data_o(rom_data)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_QEST: begin
        mul_a = a_q;
        mul_b = signed'(RECIP[19:0]);
      end
      ST_QMUL: begin
        mul_a = signed'(DEN);
        mul_b = 20'(prod >>> RS);
      end
      ST_MUL_S: begin
        mul_a = 25'(c_q);
        mul_b = 20'(x1_q);
      end
      ST_MUL_G: begin
        mul_a = 25'(c_q);
        mul_b = 20'(17'(x_q) + 17'(x2_q));
      end
      ST_MUL_EG: begin
        mul_a = 25'(e_q);
        mul_b = g_q;
      end
      ST_EG: begin
        mul_a = 25'(mu_q);
        mul_b = 20'(signed'(prod[35:18]));
      end
      ST_MUL_HI: begin
        mul_a = 25'(mu_q);
        mul_b = signed'({2'b00, eg_q[17:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  afe_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = mode_i ? ST_OUT : ST_WRAP;
      end
      ST_WRAP: begin
        if (!a_q[24] && (a_q < TP)) state_d = ST_QEST;
      end
      ST_QEST:   state_d = ST_QMUL;
      ST_QMUL:   state_d = ST_QREM;
      ST_QREM:   state_d = ST_QFIX;
      ST_QFIX: begin
        if (rem_q < DEN) state_d = ST_ADDR;
      end
      ST_ADDR:   state_d = ST_ROM;
      ST_ROM:    state_d = ST_COS;
      ST_COS:    state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_MUL_G;
      ST_MUL_G:  state_d = ST_G;
      ST_G:      state_d = ST_MUL_EG;
      ST_MUL_EG: state_d = ST_EG;
      ST_EG:     state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ACC;
      ST_ACC:    state_d = ST_RND;
      ST_RND:    state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mu_q        <= STEP_SIZE_RESET;
      init_q      <= signed'(INIT_ANGLE_RESET);
      angle_q     <= signed'(INIT_ANGLE_RESET);
      x1_q        <= '0;
      x2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_STEP_SIZE:  mu_q <= cfg_data_i[23:0];
          CFG_INIT_ANGLE: init_q <= signed'(cfg_data_i[23:0]);
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_acc && mode_i) begin
        x1_q    <= '0;
        x2_q    <= '0;
        angle_q <= init_q;
      end
      if (state_q == ST_RND) begin
        if (nw > ANGLE_MAX) begin
          angle_q <= 24'(ANGLE_MAX);
        end else if (nw < ANGLE_MIN) begin
          angle_q <= 24'(ANGLE_MIN);
        end else begin
          angle_q <= nw[23:0];
        end
        x2_q <= x1_q;
        x1_q <= x_q;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q <= sample_i;
        a_q <= 25'(angle_q);
      end
      ST_WRAP: begin
        if (a_q[24]) begin
          a_q <= a_q + signed'(TP);
        end else if (a_q >= TP) begin
          a_q <= a_q - signed'(TP);
        end
      end
      ST_QMUL:  p_q <= QW'(prod >>> RS);
      ST_QREM:  rem_q <= 25'(n_full - NW'(prod));
      ST_QFIX: begin
        if (rem_q >= DEN) begin
          rem_q <= rem_q - DEN;
          p_q   <= p_q + QW'(1);
        end
      end
      ST_ADDR: begin
        addr_q <= pq[0] ? ((B+1)'(1 << B) - (B+1)'(pr)) : (B+1)'(pr);
        neg_q  <= (pq == 2'd1) || (pq == 2'd2);
      end
      ST_COS:   c_q <= neg_q ? -signed'({2'b00, rom_data}) : signed'({2'b00, rom_data});
      ST_MUL_G: e_q <= 20'(45'(x_q) - s_rnd + 45'(x2_q));
      ST_G:     g_q <= 20'(g_rnd + 45'(x1_q));
      ST_EG:    eg_q <= prod[35:0];
      ST_MUL_HI: acc_q <= 60'(prod) <<< 18;
      ST_ACC:   acc_q <= acc_q + 60'(prod);
      ST_OUT: begin
        if (out_free) out_angle_q <= angle_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign angle_o     = out_angle_q;

  `AFE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q != ST_IDLE)
  `AFE_ASSERT_NXT(a_restart_angle, clk_i, rst_ni, in_acc && mode_i, angle_q == $past(init_q))
  `AFE_ASSERT_NXT(a_out_load, clk_i, rst_ni, state_q == ST_OUT && out_free, out_valid_q && angle_o == $past(angle_q))
  `AFE_ASSERT_IMP(a_fix_bound, clk_i, rst_ni, state_q == ST_QFIX, 26'(rem_q) < (26'(DEN) << 1))

endmodule
`default_nettype wire

>>> tb/tb_adaptive_frequency_estimator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_adaptive_frequency_estimator;
  import afe_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NQ = 1 << COS_TABLE_BITS_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] angle_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = CFG_STEP_SIZE;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  adaptive_frequency_estimator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .sample_i(sample_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .angle_o(angle_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // estimator model state
  int cos_lut [0:NQ];
  logic signed [15:0] hist_one, hist_two;
  logic signed [23:0] est_angle;
  logic [23:0] mu_reg;
  logic signed [23:0] init_angle_reg;

  logic signed [23:0] angle_queue [$];
  int errors = 0;
  int n_requests = 0;
  int n_restarts = 0;
  int n_results = 0;
  int n_saturated = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // quarter-wave cosine entry via Q4.28 series
  function automatic int lut_entry(int k);
    longint unsigned xr, xsq, term, r;
    longint acc;
    xr = (longint'(k) * HALF_PI_Q28 + longint'(NQ / 2)) >> COS_TABLE_BITS_DEF;
    xsq = (xr * xr + (64'd1 << 27)) >> 28;
    term = 64'd1 << 28;
    acc = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * xsq) >> 28) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    r = (longint'(acc) + 4096) >> 13;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : v;
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  // cosine of an angle wrapped to one turn
  function automatic longint cos_lookup(logic signed [23:0] w);
    longint tp, a, p, quad, rem;
    tp = longint'(TWO_PI_Q20);
    a = longint'(w) % tp;
    if (a < 0) a += tp;
    p = (a * 8 * NQ + tp) / (2 * tp);
    if (p >= 4 * NQ) p = 0;
    quad = p / NQ;
    rem = p % NQ;
    case (quad)
      0: return cos_lut[rem];
      1: return -cos_lut[NQ - rem];
      2: return -cos_lut[rem];
      default: return cos_lut[NQ - rem];
    endcase
  endfunction

  // next angle estimate after one request
  function automatic logic signed [23:0] predict_angle(logic m, logic signed [15:0] smp);
    longint x, x1, x2, c, s, e, g, delta, nw;
    if (m) begin
      hist_one = '0;
      hist_two = '0;
      est_angle = init_angle_reg;
    end else begin
      x = smp;
      x1 = hist_one;
      x2 = hist_two;
      c = cos_lookup(est_angle);
      s = round_shift(c * x1, 14) - x2;
      e = x - s;
      g = round_shift((x + x2) * c, 15) + x1;
      delta = round_shift(longint'(mu_reg) * (e * g), 34);
      nw = longint'(est_angle) - delta;
      if (nw > 8388607 || nw < -8388608) n_saturated++;
      if (nw > 8388607) nw = 8388607;
      if (nw < -8388608) nw = -8388608;
      est_angle = nw[23:0];
      hist_two = hist_one;
      hist_one = smp;
    end
    return est_angle;
  endfunction

  // send one request, gap drawn per request
  task automatic send_request(input logic m, input logic signed [15:0] smp);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    angle_queue.push_back(predict_angle(m, smp));
    n_requests++;
    if (m) n_restarts++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STEP_SIZE) begin
      mu_reg = data;
    end else begin
      init_angle_reg = data;
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(($urandom_range(0, 19) == 0), 16'($urandom));
    end
  endtask

  // clean sinusoid with optional noise, restart first
  task automatic send_tone(input int count, input int noise);
    real amp, w, ph;
    int v;
    amp = $urandom_range(500, 32700);
    w = $urandom_range(50, 3100) / 1000.0;
    ph = $urandom_range(0, 6283) / 1000.0;
    send_request(1'b1, 16'($urandom));
    for (int n = 0; n < count; n++) begin
      v = $rtoi(amp * $cos(w * n + ph));
      if (noise > 0) v += $urandom_range(0, 2 * noise) - noise;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_request(1'b0, 16'(v));
    end
  endtask

  // extremes of both fields, restart, saturation and zero gain
  task automatic test_directed();
    send_request(1'b0, 16'sd32767);
    send_request(1'b0, -16'sd32768);
    send_request(1'b0, 16'sd32767);
    send_request(1'b0, 16'sd0);
    send_request(1'b0, -16'sd1);
    send_request(1'b1, 16'sd32767);
    send_request(1'b0, 16'sd1);
    wait_drained();
    write_cfg(CFG_STEP_SIZE, 24'hFFFFFF);
    write_cfg(CFG_INIT_ANGLE, 24'h7FFFFF);
    send_request(1'b1, '0);
    for (int i = 0; i < 5; i++) begin
      send_request(1'b0, (i % 2) ? -16'sd32768 : 16'sd32767);
    end
    wait_drained();
    write_cfg(CFG_INIT_ANGLE, 24'h800000);
    send_request(1'b1, -16'sd1);
    for (int i = 0; i < 5; i++) begin
      send_request(1'b0, (i % 3 == 0) ? 16'sd32767 : -16'sd32768);
    end
    wait_drained();
    write_cfg(CFG_STEP_SIZE, 24'd0);
    send_request(1'b1, '0);
    send_request(1'b0, 16'sd20000);
    send_request(1'b0, -16'sd20000);
    send_request(1'b0, 16'sd12345);
    wait_drained();
  endtask

  // several register settings, each followed by tones and random requests
  task automatic test_config_sweep();
    logic [23:0] mus [6];
    logic [23:0] inits [6];
    mus = '{24'd16777, 24'd0, 24'hFFFFFF, 24'd1, 24'd300000, 24'($urandom)};
    inits = '{24'd0, 24'h800000, 24'h7FFFFF, 24'd3294198, 24'hCDBA12, 24'($urandom)};
    for (int k = 0; k < 6; k++) begin
      write_cfg(CFG_STEP_SIZE, mus[k]);
      write_cfg(CFG_INIT_ANGLE, inits[k]);
      send_tone(60, 0);
      send_tone(40, 800);
      send_random(30);
      wait_drained();
    end
  endtask

  // mostly well-formed tones, some noise; stretches without idling
  task automatic test_tones();
    write_cfg(CFG_STEP_SIZE, 24'd200000);
    write_cfg(CFG_INIT_ANGLE, 24'd1000000);
    for (int k = 0; k < 10; k++) begin
      tx_no_idle = (k % 3 == 0);
      rx_no_idle = (k % 4 == 1);
      send_tone($urandom_range(20, 60), (k % 2) ? 0 : $urandom_range(0, 3000));
      if (k % 5 == 4) send_random(20);
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    wait_drained();
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    rx_hold = 400;
    tx_no_idle = 1'b1;
    send_tone(30, 100);
    tx_no_idle = 1'b0;
    wait_drained();
  endtask

  // sender stops until every result is back, mid-stream
  task automatic test_pause();
    send_random(100);
    wait_drained();
    send_random(100);
    wait_drained();
  endtask

  // receiver hold countdown
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) rx_hold--;
    end
  end

  // result checker
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_results++;
        if (angle_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result angle=%0d", angle_o));
        end else begin
          logic signed [23:0] want;
          want = angle_queue.pop_front();
          if (angle_o !== want) begin
            report_mismatch($sformatf("angle got %0d want %0d", angle_o, want));
          end
        end
        left = rx_no_idle ? 0 : $urandom_range(0, 15);
      end
      out_stall_i <= (rx_hold > 0) || (left > 0);
      if (left > 0) left--;
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k <= NQ; k++) cos_lut[k] = lut_entry(k);
    mu_reg = STEP_SIZE_RESET;
    init_angle_reg = INIT_ANGLE_RESET;
    hist_one = '0;
    hist_two = '0;
    est_angle = INIT_ANGLE_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_tones();
    test_backpressure();
    test_pause();
    write_cfg(CFG_STEP_SIZE, STEP_SIZE_RESET);
    write_cfg(CFG_INIT_ANGLE, INIT_ANGLE_RESET);
    send_tone(120, 200);
    send_random(300);
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (angle_queue.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", angle_queue.size()));
    end
    $display("covered %0d requests (%0d restarts), %0d results checked", n_requests,
             n_restarts, n_results);
    $display("gain and initial angle at both extremes, %0d saturated updates",
             n_saturated);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
